// ----- rtl/byte_ring_fifo_with_peek_unit_assert.svh -----
// assertion macros for the byte ring fifo checker
// no dependencies; included by the checker file
`ifndef BYTE_RING_FIFO_WITH_PEEK_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_UNIT_ASSERT_SVH

// property checked only while out of reset
`define BRFP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define BRFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/brfp_pkg.sv -----
// shared types and constants for the byte ring fifo with peek
// no dependencies
package brfp_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 9;
    localparam int FILL_W   = 9;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;

    // ring length after reset, before clamping to the storage depth
    localparam int RING_LEN_RESET = 256;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SNIFF = 3'd3,
        OP_FLUSH = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-transaction result, excluding the byte read from storage
    typedef struct packed {
        logic                data_valid;
        status_t             status;
        logic [FILL_W-1:0]   fill_level;
        logic [TOTAL_W-1:0]  total_reads;
        logic [TOTAL_W-1:0]  total_writes;
    } brfp_res_t;

endpackage

// ----- rtl/brfp_ring.sv -----
// ring storage, pointers, totals and length register
// depends on brfp_pkg
module brfp_ring #(
    parameter int MAX_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [brfp_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                         exec_en,
    input  logic [brfp_pkg::OP_W-1:0]    opcode,
    input  logic [brfp_pkg::DATA_W-1:0]  data_in,
    output logic [brfp_pkg::DATA_W-1:0]  rd_data,
    output brfp_pkg::brfp_res_t          res
);
    import brfp_pkg::*;

    localparam int PTR_W     = $clog2(MAX_DEPTH);
    localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W     = (LEN_W > FILL_W) ? LEN_W : FILL_W;
    localparam int RESET_LEN = (RING_LEN_RESET > MAX_DEPTH) ? MAX_DEPTH : RING_LEN_RESET;

    logic [DATA_W-1:0]  mem [MAX_DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;
    brfp_res_t          res_reg;
    brfp_res_t          res_next;

    logic [LEN_W-1:0]   len_reg,      len_next;
    logic [PTR_W-1:0]   last_idx_reg, last_idx_next;
    logic [PTR_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg,     fill_next;
    logic [TOTAL_W-1:0] reads_reg,    reads_next;
    logic [TOTAL_W-1:0] writes_reg,   writes_next;

    logic [LEN_W-1:0]   cfg_len;
    logic [PTR_W-1:0]   sniff_addr;
    logic [PTR_W-1:0]   rd_addr;
    logic               full;
    logic               empty;
    logic               do_write;
    logic               dv;
    status_t            st;

    function automatic logic [PTR_W-1:0] advance(
        input logic [PTR_W-1:0] p,
        input logic [LEN_W-1:0] len
    );
        logic [PTR_W:0] n;
        n = {1'b0, p} + 1'b1;
        if (n >= (PTR_W+1)'(len)) begin
            return '0;
        end
        return n[PTR_W-1:0];
    endfunction

    // clamp the written length into one to the storage depth
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_len = LEN_W'(1);
        end else if (32'(cfg_wr_data) > 32'(MAX_DEPTH)) begin
            cfg_len = LEN_W'(MAX_DEPTH);
        end else begin
            cfg_len = LEN_W'(cfg_wr_data);
        end
    end

    assign len_next      = cfg_wr_en ? cfg_len : len_reg;
    assign last_idx_next = cfg_wr_en ? PTR_W'(cfg_len - 1'b1) : last_idx_reg;

    assign full       = CMP_W'(fill_reg) >= CMP_W'(len_reg);
    assign empty      = (fill_reg == '0);
    assign sniff_addr = (wr_ptr_reg == '0) ? last_idx_reg : wr_ptr_reg - 1'b1;
    assign rd_addr    = (opcode == OP_SNIFF) ? sniff_addr : rd_ptr_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        reads_next  = reads_reg;
        writes_next = writes_reg;
        do_write    = 1'b0;
        dv          = 1'b0;
        st          = ST_OK;
        if (exec_en) begin
            unique case (opcode) inside
                OP_WRITE: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        do_write    = 1'b1;
                        writes_next = writes_reg + 1'b1;
                        fill_next   = fill_reg + 1'b1;
                        wr_ptr_next = advance(wr_ptr_reg, len_reg);
                    end
                end
                OP_READ: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        dv          = 1'b1;
                        reads_next  = reads_reg + 1'b1;
                        fill_next   = fill_reg - 1'b1;
                        rd_ptr_next = advance(rd_ptr_reg, len_reg);
                    end
                end
                OP_PEEK, OP_SNIFF: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        dv = 1'b1;
                    end
                end
                OP_FLUSH: begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    fill_next   = '0;
                    reads_next  = '0;
                    writes_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res_next              = res_reg;
        res_next.data_valid   = dv;
        res_next.status       = st;
        res_next.fill_level   = fill_next;
        res_next.total_reads  = reads_next;
        res_next.total_writes = writes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(RESET_LEN);
            last_idx_reg <= PTR_W'(RESET_LEN - 1);
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
            reads_reg    <= '0;
            writes_reg   <= '0;
        end else begin
            len_reg      <= len_next;
            last_idx_reg <= last_idx_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fill_reg     <= fill_next;
            reads_reg    <= reads_next;
            writes_reg   <= writes_next;
        end
    end

    // storage and result capture
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_ptr_reg] <= data_in;
        end
        if (exec_en) begin
            rd_data_reg <= mem[rd_addr];
            res_reg     <= res_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign res     = res_reg;

endmodule

// ----- rtl/byte_ring_fifo_with_peek_unit.sv -----
// top level of the byte ring fifo with peek and sniff
// depends on brfp_pkg and brfp_ring
//
// usage
//  - input channel s_valid/s_ready carries s_opcode and s_data_in; one
//    transaction is write, read, peek, sniff or flush
//  - result channel m_valid/m_ready returns one transaction per input:
//    byte, data valid flag, status, fill level and the two running totals
//  - cfg_wr_en/cfg_wr_data sets the ring length; write it only while idle
//  - throughput: one transaction per cycle while the receiver does not stall,
//    set by the single storage access and pointer update in the execute stage
//  - result path: execute stage, then output register, then m_valid
//  - a stalled receiver holds the output register; one more transaction is
//    taken into the execute stage, after which s_ready drops
//  - reset clears pointers, totals and fill and sets the ring length to 256
//    (clamped to MAX_DEPTH); storage contents are not cleared, no sweep
module byte_ring_fifo_with_peek_unit #(
    parameter int MAX_DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [brfp_pkg::CFG_W-1:0]      cfg_wr_data,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [brfp_pkg::OP_W-1:0]       s_opcode,
    input  logic [brfp_pkg::DATA_W-1:0]     s_data_in,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [brfp_pkg::DATA_W-1:0]     m_result_data,
    output logic                            m_data_valid,
    output logic [brfp_pkg::STATUS_W-1:0]   m_status,
    output logic [brfp_pkg::FILL_W-1:0]     m_fill_level,
    output logic [brfp_pkg::TOTAL_W-1:0]    m_total_reads,
    output logic [brfp_pkg::TOTAL_W-1:0]    m_total_writes
);
    import brfp_pkg::*;

    logic               st_valid_reg, st_valid_next;
    logic               m_valid_reg,  m_valid_next;
    logic               out_free;
    logic               exec_en;
    logic               move;
    logic [DATA_W-1:0]  rd_data;
    brfp_res_t          res;

    logic [DATA_W-1:0]   m_result_data_reg;
    logic                m_data_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [FILL_W-1:0]   m_fill_level_reg;
    logic [TOTAL_W-1:0]  m_total_reads_reg;
    logic [TOTAL_W-1:0]  m_total_writes_reg;

    // output register free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    // execute stage free when empty or moving on
    assign s_ready  = !st_valid_reg || out_free;
    assign exec_en  = s_valid && s_ready;
    assign move     = st_valid_reg && out_free;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (exec_en) begin
            st_valid_next = 1'b1;
        end else if (move) begin
            st_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // execute stage: storage access, pointer and total update
    brfp_ring #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .exec_en     (exec_en),
        .opcode      (s_opcode),
        .data_in     (s_data_in),
        .rd_data     (rd_data),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // output register; the byte reads as zero unless a stored byte came back
    always_ff @(posedge aclk) begin
        if (move) begin
            m_result_data_reg  <= res.data_valid ? rd_data : '0;
            m_data_valid_reg   <= res.data_valid;
            m_status_reg       <= res.status;
            m_fill_level_reg   <= res.fill_level;
            m_total_reads_reg  <= res.total_reads;
            m_total_writes_reg <= res.total_writes;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_data  = m_result_data_reg;
    assign m_data_valid   = m_data_valid_reg;
    assign m_status       = m_status_reg;
    assign m_fill_level   = m_fill_level_reg;
    assign m_total_reads  = m_total_reads_reg;
    assign m_total_writes = m_total_writes_reg;

endmodule

// ----- rtl/brfp_checker.sv -----
// port-level checks for the byte ring fifo, bound to the top level
// depends on brfp_pkg and byte_ring_fifo_with_peek_unit_assert.svh
`include "byte_ring_fifo_with_peek_unit_assert.svh"

module brfp_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic [brfp_pkg::DATA_W-1:0]     m_result_data,
    input logic                            m_data_valid,
    input logic [brfp_pkg::STATUS_W-1:0]   m_status,
    input logic [brfp_pkg::FILL_W-1:0]     m_fill_level
);
    import brfp_pkg::*;

    `BRFP_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `BRFP_ASSERT_RST(a_valid_is_ok, aclk, aresetn, (m_valid && m_data_valid) |-> (m_status == ST_OK), "byte returned with error status")
    `BRFP_ASSERT_RST(a_no_byte_zero, aclk, aresetn, (m_valid && !m_data_valid) |-> (m_result_data == '0), "nonzero byte without data valid")
    `BRFP_ASSERT_RST(a_full_has_fill, aclk, aresetn, (m_valid && m_status == ST_FULL) |-> (m_fill_level != '0), "full status with zero fill")

endmodule

bind byte_ring_fifo_with_peek_unit brfp_port_checker u_brfp_checker (.*);

// ----- tb/brfp_checker.sv -----
// result checker for the byte ring fifo with peek: watches both channels and the
// configuration port, predicts each result and compares it field by field
// depends on brfp_pkg
`timescale 1ns / 1ps

module brfp_checker #(
    parameter int MAX_DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [brfp_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [brfp_pkg::OP_W-1:0]       s_opcode,
    input  logic [brfp_pkg::DATA_W-1:0]     s_data_in,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [brfp_pkg::DATA_W-1:0]     m_result_data,
    input  logic                            m_data_valid,
    input  logic [brfp_pkg::STATUS_W-1:0]   m_status,
    input  logic [brfp_pkg::FILL_W-1:0]     m_fill_level,
    input  logic [brfp_pkg::TOTAL_W-1:0]    m_total_reads,
    input  logic [brfp_pkg::TOTAL_W-1:0]    m_total_writes,
    output int                              errors,
    output int                              pending
);
    import brfp_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        brfp_res_t         res;
    } fifo_result_t;

    fifo_result_t       expected_results[$];

    // shadow copy of the ring
    logic [DATA_W-1:0]  ring_mem [MAX_DEPTH];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    logic [TOTAL_W-1:0] rd_total;
    logic [TOTAL_W-1:0] wr_total;
    logic [CFG_W-1:0]   ring_len;
    int                 err_cnt = 0;

    // register value clamped to 1..MAX_DEPTH
    function automatic int unsigned used_length();
        if (ring_len == '0)
            return 1;
        if (int'(ring_len) > MAX_DEPTH)
            return MAX_DEPTH;
        return int'(ring_len);
    endfunction

    function automatic int unsigned next_ptr(input int unsigned p);
        int unsigned n;
        n = p + 1;
        if (n >= used_length())
            n = 0;
        return n;
    endfunction

    function automatic fifo_result_t apply_fifo_op(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] din);
        fifo_result_t       r;
        logic [TOTAL_W-1:0] fill;
        int unsigned        prev;
        r = '0;
        r.res.status = ST_OK;
        fill = wr_total - rd_total;
        case (op)
            OP_WRITE: begin
                if (fill >= used_length()) begin
                    r.res.status = ST_FULL;
                end else begin
                    ring_mem[wr_ptr] = din;
                    wr_total = wr_total + 1'b1;
                    wr_ptr = next_ptr(wr_ptr);
                end
            end
            OP_READ: begin
                if (fill == '0) begin
                    r.res.status = ST_EMPTY;
                end else begin
                    r.rdata = ring_mem[rd_ptr];
                    r.res.data_valid = 1'b1;
                    rd_total = rd_total + 1'b1;
                    rd_ptr = next_ptr(rd_ptr);
                end
            end
            OP_PEEK: begin
                if (fill == '0) begin
                    r.res.status = ST_EMPTY;
                end else begin
                    r.rdata = ring_mem[rd_ptr];
                    r.res.data_valid = 1'b1;
                end
            end
            OP_SNIFF: begin
                if (fill == '0) begin
                    r.res.status = ST_EMPTY;
                end else begin
                    prev = (wr_ptr == 0) ? used_length() - 1 : wr_ptr - 1;
                    r.rdata = ring_mem[prev];
                    r.res.data_valid = 1'b1;
                end
            end
            OP_FLUSH: begin
                wr_ptr = 0;
                rd_ptr = 0;
                rd_total = '0;
                wr_total = '0;
            end
            default: begin
            end
        endcase
        fill = wr_total - rd_total;
        r.res.fill_level = fill[FILL_W-1:0];
        r.res.total_reads = rd_total;
        r.res.total_writes = wr_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        fifo_result_t want;
        if (!aresetn) begin
            wr_ptr = 0;
            rd_ptr = 0;
            rd_total = '0;
            wr_total = '0;
            ring_len = CFG_W'(RING_LEN_RESET);
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                ring_len = cfg_wr_data;
            if (s_valid && s_ready)
                expected_results.push_back(apply_fifo_op(s_opcode, s_data_in));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_data", TOTAL_W'(want.rdata), TOTAL_W'(m_result_data));
                    check_field("data_valid", TOTAL_W'(want.res.data_valid),
                                TOTAL_W'(m_data_valid));
                    check_field("status", TOTAL_W'(want.res.status), TOTAL_W'(m_status));
                    check_field("fill_level", TOTAL_W'(want.res.fill_level),
                                TOTAL_W'(m_fill_level));
                    check_field("total_reads", want.res.total_reads, m_total_reads);
                    check_field("total_writes", want.res.total_writes, m_total_writes);
                end
            end
        end
        errors <= err_cnt;
        pending <= expected_results.size();
    end

endmodule

// ----- tb/tb_byte_ring_fifo_with_peek_unit.sv -----
// top of the byte ring fifo testbench: clock, reset, stimulus, receiver stalls
// and the verdict; depends on brfp_pkg, brfp_checker and the block itself
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_peek_unit;
    import brfp_pkg::*;

    // opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int NUM_PHASES       = 12;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int RING_FULL_DEPTH  = 256;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [OP_W-1:0]        s_opcode;
    logic [DATA_W-1:0]      s_data_in;
    logic                   m_valid;
    logic                   m_ready;
    logic [DATA_W-1:0]      m_result_data;
    logic                   m_data_valid;
    logic [STATUS_W-1:0]    m_status;
    logic [FILL_W-1:0]      m_fill_level;
    logic [TOTAL_W-1:0]     m_total_reads;
    logic [TOTAL_W-1:0]     m_total_writes;

    int  mismatches;
    int  outstanding;
    int  items_sent = 0;
    int  settings_used = 0;
    bit  no_idle = 1'b0;
    int  ready_hold = 0;

    byte_ring_fifo_with_peek_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_data_in      (s_data_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_data  (m_result_data),
        .m_data_valid   (m_data_valid),
        .m_status       (m_status),
        .m_fill_level   (m_fill_level),
        .m_total_reads  (m_total_reads),
        .m_total_writes (m_total_writes)
    );

    // prediction and comparison live in the checker; it hands back counts only
    brfp_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_data_in      (s_data_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_data  (m_result_data),
        .m_data_valid   (m_data_valid),
        .m_status       (m_status),
        .m_fill_level   (m_fill_level),
        .m_total_reads  (m_total_reads),
        .m_total_writes (m_total_writes),
        .errors         (mismatches),
        .pending        (outstanding)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one input transaction; valid is only dropped when a gap follows
    task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din);
        int gap;
        s_valid <= 1'b1;
        s_opcode <= op;
        s_data_in <= din;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // random transaction; write_pct steers the ring towards full or empty
    task automatic random_op(input int write_pct);
        int              r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            op = OP_FLUSH;
        end else if (r < 6) begin
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end else if (r < 6 + (write_pct * 94) / 100) begin
            op = OP_WRITE;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 6)
                op = OP_READ;
            else if (r < 8)
                op = OP_PEEK;
            else
                op = OP_SNIFF;
        end
        send_op(op, DATA_W'($urandom_range(0, 255)));
    endtask

    // hold the sender until every result is back, plus the pipeline depth
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_ring_length(input logic [CFG_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // fixed extremes first, including the clamped values, then random lengths
    function automatic logic [CFG_W-1:0] phase_length(input int idx);
        case (idx)
            0:       return CFG_W'(1);
            1:       return CFG_W'(256);
            2:       return CFG_W'(0);
            3:       return CFG_W'(511);
            4:       return CFG_W'(2);
            5:       return CFG_W'(257);
            6:       return CFG_W'(255);
            7:       return CFG_W'(3);
            default: return CFG_W'($urandom_range(1, 256));
        endcase
    endfunction

    // receiver: ready bursts, short stalls, a few long stalls and stall-free stretches
    initial begin
        int r;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    ready_hold = $urandom_range(0, 8);
                end else if (r < 90) begin
                    m_ready <= 1'b0;
                    ready_hold = $urandom_range(0, 3);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    ready_hold = $urandom_range(10, 40);
                end else begin
                    m_ready <= 1'b1;
                    ready_hold = $urandom_range(30, 120);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int pause_at;
        s_valid <= 1'b0;
        s_opcode <= OP_WRITE;
        s_data_in <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty ring: read, peek and sniff all report empty
        send_op(OP_READ, 8'h00);
        send_op(OP_PEEK, 8'hFF);
        send_op(OP_SNIFF, 8'h00);
        // extreme data bytes, then look at both ends
        send_op(OP_WRITE, 8'h00);
        send_op(OP_WRITE, 8'hFF);
        send_op(OP_WRITE, 8'hA5);
        send_op(OP_WRITE, 8'h5A);
        send_op(OP_PEEK, 8'h00);
        send_op(OP_SNIFF, 8'h00);
        send_op(OP_READ, 8'h00);
        send_op(OP_READ, 8'hFF);
        // spare opcodes leave the state alone
        send_op(OP_SPARE_FIRST, 8'hFF);
        send_op(OP_W'(OP_SPARE_FIRST + 1), 8'h00);
        send_op(OP_SPARE_LAST, 8'hFF);
        // flush with data still held, then the empty cases again
        send_op(OP_FLUSH, 8'hFF);
        send_op(OP_READ, 8'hFF);
        send_op(OP_SNIFF, 8'hFF);
        send_op(OP_WRITE, 8'h3C);
        send_op(OP_SNIFF, 8'h00);
        send_op(OP_READ, 8'h00);
        send_op(OP_PEEK, 8'h00);

        // fill every storage entry, so that later length changes with data in the
        // ring never touch an entry that was never written; ends with the write
        // pointer wrapped round to one and a dropped write on a full ring
        repeat (RING_FULL_DEPTH) send_op(OP_WRITE, DATA_W'($urandom_range(0, 255)));
        send_op(OP_WRITE, 8'hC3);
        send_op(OP_SNIFF, 8'h00);
        send_op(OP_PEEK, 8'h00);
        wait_for_results();

        // random phases, each under a new ring length; the ring is not flushed
        // between phases, so lengths also change with data in use
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_ring_length(phase_length(phase));
            no_idle = (phase % 4 == 3);
            pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == pause_at)
                    wait_for_results();
                case (phase % 3)
                    0:       random_op(75);
                    1:       random_op(50);
                    default: random_op(30);
                endcase
            end
            wait_for_results();
        end

        if (outstanding != 0)
            $error("results still outstanding at the end: %0d", outstanding);
        $display("covered %0d transactions under %0d ring length settings", items_sent,
                 settings_used);
        $display("lengths included 1, the full depth and out-of-range values 0 and 511");
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
